// File: design/slt_pkg.sv
package slt_pkg;

  localparam int Capacity   = 64;
  localparam int KeyWidth   = 32;
  localparam int IdxWidth   = $clog2(Capacity);
  localparam int CountWidth = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_DELETE   = 3'd1,
    CMD_RETRIEVE = 3'd2,
    CMD_RESET    = 3'd3,
    CMD_GET_NEXT = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_PAST_END  = 2'd3
  } status_e;

  // Write enables broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

// File: design/slt_cell.sv
module slt_cell
  import slt_pkg::*;
(
  input  logic                clk_i,
  input  cell_ctl_t           ctl_i,
  input  logic [KeyWidth-1:0] key_i,
  input  logic                valid_i,
  input  logic                prev_ge_i,
  input  logic [KeyWidth-1:0] prev_entry_i,
  input  logic [KeyWidth-1:0] next_entry_i,
  output logic [KeyWidth-1:0] entry_o,
  output logic                ge_o,
  output logic                eq_o
);

  logic [KeyWidth-1:0] entry_q, entry_d;

  // An empty cell counts as larger than any key, so the first cell that
  // reports ge is where an insert lands and where a delete starts.
  assign ge_o    = !valid_i || (entry_q >= key_i);
  assign eq_o    = valid_i && (entry_q == key_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && ge_o) begin
      entry_d = prev_ge_i ? prev_entry_i : key_i;
    end else if (ctl_i.del && ge_o) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: design/sorted_list_table.sv
// Channel   Direction  Handshake          Payload
// command   in         start_i / busy_o   command_i, key_i
// result    out        valid_o            status_o, found_o, item_value_o, count_o, is_full_o
//
// Each command is accepted at a clock edge and its result is shown in the
// following cycle for exactly one cycle. busy_o stays low, since all cells of
// the chain compare and shift in parallel when a command is accepted.
// The receiver cannot stall; results are never held back.
// Reset empties the table and sets the cursor to the start; entry contents
// are not cleared and are never read before they are written.
module sorted_list_table
  import slt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [2:0]            command_i,
  input  logic [KeyWidth-1:0]   key_i,
  output logic                  valid_o,
  output logic [1:0]            status_o,
  output logic                  found_o,
  output logic [KeyWidth-1:0]   item_value_o,
  output logic [CountWidth-1:0] count_o,
  output logic                  is_full_o
);

  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] cursor_q, cursor_d;
  logic                  valid_q;
  status_e               status_d, status_q;
  logic                  found_d, found_q;
  logic [KeyWidth-1:0]   value_d, value_q;

  logic                  accept;
  logic                  full;
  logic                  hit;
  cmd_e                  cmd;
  cell_ctl_t             ctl;
  logic [KeyWidth-1:0]   cursor_data;

  logic [Capacity-1:0]   ge;
  logic [Capacity-1:0]   eq;
  logic [Capacity-1:0]   cell_valid;
  logic [KeyWidth-1:0]   entry [Capacity];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign cmd    = cmd_e'(command_i);
  assign full   = (count_q == CountWidth'(Capacity));
  assign hit    = |eq;

  assign ctl.ins = accept && (cmd == CMD_INSERT) && !full;
  assign ctl.del = accept && (cmd == CMD_DELETE) && hit;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                prev_ge;
    logic [KeyWidth-1:0] prev_entry;
    logic [KeyWidth-1:0] next_entry;

    assign cell_valid[i] = (CountWidth'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_ge    = 1'b0;
      assign prev_entry = key_i;
    end else begin : g_mid
      assign prev_ge    = ge[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    slt_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .key_i        (key_i),
      .valid_i      (cell_valid[i]),
      .prev_ge_i    (prev_ge),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .entry_o      (entry[i]),
      .ge_o         (ge[i]),
      .eq_o         (eq[i])
    );
  end

  // One-hot select of the entry under the cursor.
  always_comb begin
    cursor_data = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (cursor_q[IdxWidth-1:0] == IdxWidth'(i)) begin
        cursor_data = cursor_data | entry[i];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    status_d = ST_OK;
    found_d  = 1'b0;
    value_d  = '0;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CountWidth'(1);
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          found_d = 1'b1;
          count_d = count_q - CountWidth'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      CMD_RETRIEVE: begin
        if (hit) begin
          found_d = 1'b1;
          value_d = key_i;
        end
      end
      CMD_RESET: begin
        cursor_d = '0;
      end
      CMD_GET_NEXT: begin
        if (cursor_q < count_q) begin
          value_d  = cursor_data;
          cursor_d = cursor_q + CountWidth'(1);
        end else begin
          status_d = ST_PAST_END;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q  <= count_d;
        cursor_q <= cursor_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      found_q  <= found_d;
      value_q  <= value_d;
    end
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign found_o      = found_q;
  assign item_value_o = value_q;
  assign count_o      = count_q;
  assign is_full_o    = full;

endmodule

// File: design/slt_checker.sv
module slt_checker
  import slt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  valid_o,
  input logic [1:0]            status_o,
  input logic                  found_o,
  input logic [KeyWidth-1:0]   item_value_o,
  input logic [CountWidth-1:0] count_o,
  input logic                  is_full_o
);

  // Every accepted request yields its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> valid_o)
    else $error("result missing after an accepted request");

  // A full-table rejection only happens when the table is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_FULL) |-> is_full_o)
    else $error("full status reported on a table that is not full");

  // A match is always reported with ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && found_o) |-> (status_o == ST_OK))
    else $error("found set together with an error status");

  // A rejected request never carries a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |-> (item_value_o == '0))
    else $error("value reported together with an error status");

  // The entry count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (count_o <= CountWidth'(Capacity)))
    else $error("entry count beyond capacity");

endmodule

bind sorted_list_table slt_checker u_slt_checker (.*);
